### design/dsu_pkg.sv
// Shared codes, command and status types for the union-find core.
`default_nettype none

package dsu_pkg;

	// request kinds
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_FIND  = 2'd1;
	localparam logic [1:0] REQ_MERGE = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_DUP    = 2'd2;

	// address source shared by all three RAMs in a cycle
	typedef enum logic [2:0] {
		ADDR_A,
		ADDR_B,
		ADDR_LA,
		ADDR_LB,
		ADDR_LOSER,
		ADDR_NEXT,
		ADDR_WINNER,
		ADDR_TAIL
	} addr_sel_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_A,
		RES_LEAD,
		RES_LA,
		RES_WIN
	} res_sel_t;

	typedef struct packed {
		logic       load_req;
		addr_sel_t  addr_sel;
		logic       add;
		logic       lead_we;
		logic       next_we;
		logic       size_we;
		logic       la_ld;
		logic       lb_ld;
		logic       sa_ld;
		logic       pick;
		logic       tail_w;
		logic       tail_next;
		logic       res_ld;
		res_sel_t   res_sel;
		logic [1:0] res_status;
		logic       push;
	} dsu_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       a_range;
		logic       a_present;
		logic       b_ok;
		logic       lead_eq;
		logic       next_none;
		logic       out_free;
	} dsu_stat_t;

endpackage

`default_nettype wire

### design/dsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### design/dsu_ctrl.sv
// Controller state machine: sequences add, find and merge over the datapath.
`default_nettype none

module dsu_ctrl
	import dsu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire dsu_stat_t stat,
	output dsu_cmd_t       cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_RD_ONE  = 4'd2;
	localparam logic [3:0] S_RD_LA   = 4'd3;
	localparam logic [3:0] S_RD_LB   = 4'd4;
	localparam logic [3:0] S_RD_SA   = 4'd5;
	localparam logic [3:0] S_RD_SB   = 4'd6;
	localparam logic [3:0] S_RELABEL = 4'd7;
	localparam logic [3:0] S_WALK_L  = 4'd8;
	localparam logic [3:0] S_WALK_T  = 4'd9;
	localparam logic [3:0] S_JOIN    = 4'd10;
	localparam logic [3:0] S_FINISH  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.addr_sel = ADDR_A;
		cmd.res_sel  = RES_ZERO;
		state_d      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (stat.req_type == REQ_ADD) begin
					priority if (!stat.a_range) begin
						cmd.res_ld     = 1'b1;
						cmd.res_status = ST_ABSENT;
						state_d        = S_FINISH;
					end else if (stat.a_present) begin
						state_d = S_RD_ONE;
					end else begin
						cmd.add        = 1'b1;
						cmd.lead_we    = 1'b1;
						cmd.next_we    = 1'b1;
						cmd.size_we    = 1'b1;
						cmd.res_ld     = 1'b1;
						cmd.res_sel    = RES_A;
						cmd.res_status = ST_OK;
						state_d        = S_FINISH;
					end
				end else if (!(stat.a_range && stat.a_present) ||
				             (stat.req_type == REQ_MERGE && !stat.b_ok)) begin
					cmd.res_ld     = 1'b1;
					cmd.res_status = ST_ABSENT;
					state_d        = S_FINISH;
				end else if (stat.req_type == REQ_MERGE) begin
					state_d = S_RD_LA;
				end else begin
					state_d = S_RD_ONE;
				end
			end
			S_RD_ONE: begin
				cmd.res_ld     = 1'b1;
				cmd.res_sel    = RES_LEAD;
				cmd.res_status = (stat.req_type == REQ_ADD) ? ST_DUP : ST_OK;
				state_d        = S_FINISH;
			end
			S_RD_LA: begin
				cmd.la_ld    = 1'b1;
				cmd.addr_sel = ADDR_B;
				state_d      = S_RD_LB;
			end
			S_RD_LB: begin
				cmd.lb_ld = 1'b1;
				if (stat.lead_eq) begin
					cmd.res_ld     = 1'b1;
					cmd.res_sel    = RES_LA;
					cmd.res_status = ST_OK;
					state_d        = S_FINISH;
				end else begin
					cmd.addr_sel = ADDR_LA;
					state_d      = S_RD_SA;
				end
			end
			S_RD_SA: begin
				cmd.sa_ld    = 1'b1;
				cmd.addr_sel = ADDR_LB;
				state_d      = S_RD_SB;
			end
			S_RD_SB: begin
				cmd.pick = 1'b1;
				state_d  = S_RELABEL;
			end
			S_RELABEL: begin
				cmd.addr_sel = ADDR_LOSER;
				cmd.lead_we  = 1'b1;
				state_d      = S_WALK_L;
			end
			S_WALK_L: begin
				// one losing-list member relabelled per cycle
				if (stat.next_none) begin
					cmd.addr_sel = ADDR_WINNER;
					cmd.tail_w   = 1'b1;
					state_d      = S_WALK_T;
				end else begin
					cmd.addr_sel = ADDR_NEXT;
					cmd.lead_we  = 1'b1;
				end
			end
			S_WALK_T: begin
				if (stat.next_none) begin
					cmd.addr_sel = ADDR_TAIL;
					cmd.next_we  = 1'b1;
					state_d      = S_JOIN;
				end else begin
					cmd.addr_sel  = ADDR_NEXT;
					cmd.tail_next = 1'b1;
				end
			end
			S_JOIN: begin
				cmd.addr_sel   = ADDR_WINNER;
				cmd.size_we    = 1'b1;
				cmd.res_ld     = 1'b1;
				cmd.res_sel    = RES_WIN;
				cmd.res_status = ST_OK;
				state_d        = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### design/dsu_datapath.sv
// Datapath: presence bits, leader/next/size RAMs, walk registers, output register.
`default_nettype none

module dsu_datapath
	import dsu_pkg::*;
#(
	parameter int NODE_COUNT = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] in_type,
	input  wire logic [7:0] in_node_a,
	input  wire logic [7:0] in_node_b,
	input  wire dsu_cmd_t   cmd,
	output dsu_stat_t       stat,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_leader,
	output logic [1:0]      out_status
);

	// only node numbers below 256 can ever be present
	localparam int         PD   = (NODE_COUNT < 256) ? NODE_COUNT : 256;
	localparam int         AW   = $clog2(PD);
	localparam logic [8:0] PD_W = 9'(PD);

	logic [1:0]    type_q;
	logic [7:0]    a_q;
	logic [7:0]    b_q;
	logic [PD-1:0] present_q;
	logic [AW-1:0] la_q, lb_q, w_q, l_q, tail_q;
	logic [AW:0]   sa_q, sum_q;
	logic [7:0]    res_lead_q;
	logic [1:0]    res_stat_q;
	logic          out_valid_q;
	logic [7:0]    out_lead_q;
	logic [1:0]    out_stat_q;

	logic [AW-1:0] a_idx, b_idx, addr;
	logic [AW-1:0] lead_rd, lead_wd;
	logic [AW:0]   next_rd, next_wd;
	logic [AW:0]   size_rd, size_wd;
	logic          b_range;
	logic          la_smaller;
	logic [AW+1:0] size_sum;
	logic [7:0]    res_lead;

	assign a_idx = a_q[AW-1:0];
	assign b_idx = b_q[AW-1:0];

	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_A:      addr = a_idx;
			ADDR_B:      addr = b_idx;
			ADDR_LA:     addr = la_q;
			ADDR_LB:     addr = lb_q;
			ADDR_LOSER:  addr = l_q;
			ADDR_NEXT:   addr = next_rd[AW-1:0];
			ADDR_WINNER: addr = w_q;
			ADDR_TAIL:   addr = tail_q;
			default:     addr = a_idx;
		endcase
	end

	// add writes a fresh singleton; otherwise relabel / append / size update
	assign lead_wd = cmd.add ? a_idx : w_q;
	assign next_wd = cmd.add ? {1'b1, {AW{1'b0}}} : {1'b0, l_q};
	assign size_wd = cmd.add ? (AW+1)'(1) : sum_q;

	dsu_ram #(.WIDTH(AW), .DEPTH(PD)) u_lead_ram (
		.clk   (clk),
		.we    (cmd.lead_we),
		.waddr (addr),
		.wdata (lead_wd),
		.raddr (addr),
		.rdata (lead_rd)
	);

	dsu_ram #(.WIDTH(AW + 1), .DEPTH(PD)) u_next_ram (
		.clk   (clk),
		.we    (cmd.next_we),
		.waddr (addr),
		.wdata (next_wd),
		.raddr (addr),
		.rdata (next_rd)
	);

	dsu_ram #(.WIDTH(AW + 1), .DEPTH(PD)) u_size_ram (
		.clk   (clk),
		.we    (cmd.size_we),
		.waddr (addr),
		.wdata (size_wd),
		.raddr (addr),
		.rdata (size_rd)
	);

	assign b_range    = ({1'b0, b_q} < PD_W);
	assign la_smaller = (sa_q < size_rd);
	assign size_sum   = {1'b0, sa_q} + {1'b0, size_rd};

	always_comb begin
		stat.req_type  = type_q;
		stat.a_range   = ({1'b0, a_q} < PD_W);
		stat.a_present = present_q[a_idx];
		stat.b_ok      = b_range && present_q[b_idx];
		stat.lead_eq   = (lead_rd == la_q);
		stat.next_none = next_rd[AW];
		stat.out_free  = !out_valid_q || out_ready;
	end

	always_comb begin
		unique case (cmd.res_sel)
			RES_ZERO: res_lead = 8'd0;
			RES_A:    res_lead = a_q;
			RES_LEAD: res_lead = 8'(lead_rd);
			RES_LA:   res_lead = 8'(la_q);
			RES_WIN:  res_lead = 8'(w_q);
			default:  res_lead = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q <= in_type;
			a_q    <= in_node_a;
			b_q    <= in_node_b;
		end
		if (cmd.la_ld) begin
			la_q <= lead_rd;
		end
		if (cmd.lb_ld) begin
			lb_q <= lead_rd;
		end
		if (cmd.sa_ld) begin
			sa_q <= size_rd;
		end
		// tie keeps node_a's set as winner
		if (cmd.pick) begin
			w_q   <= la_smaller ? lb_q : la_q;
			l_q   <= la_smaller ? la_q : lb_q;
			sum_q <= size_sum[AW:0];
		end
		if (cmd.tail_w) begin
			tail_q <= w_q;
		end else if (cmd.tail_next) begin
			tail_q <= next_rd[AW-1:0];
		end
		if (cmd.res_ld) begin
			res_lead_q <= res_lead;
			res_stat_q <= cmd.res_status;
		end
		if (cmd.push) begin
			out_lead_q <= res_lead_q;
			out_stat_q <= res_stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.add) begin
				present_q[a_idx] <= 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_leader = out_lead_q;
	assign out_status = out_stat_q;

endmodule

`default_nettype wire

### design/disjoint_set_union_find_core.sv
// Top level of the union-find core: linked-list sets with union by size.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: node_a, node_b; s_tuser: req_type
//  m_      | out | m_tvalid/m_tready  | m_tdata: leader, status
//
// One request at a time. Add, find and a request naming an absent node finish
// without a list walk, and a self-merge ends once both leaders are read; a real
// merge walks the loser list and then the winner list, both one member per cycle
// through the registered read of the next-member RAM.
// Reset clears the presence bits and the controller; RAM contents need no reset.
// A result waiting on m_tready holds in the output register while the next
// request is taken; that request's result waits until the register frees.
`default_nettype none

module disjoint_set_union_find_core
	import dsu_pkg::*;
#(
	parameter int NODE_COUNT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [7:0] node_a, [15:8] node_b
	input  wire logic [1:0]  s_tuser,  // [1:0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // [7:0] leader, [9:8] status, [15:10] zero
);

	dsu_cmd_t   cmd;
	dsu_stat_t  stat;
	logic [7:0] leader;
	logic [1:0] status;

	dsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsu_datapath #(.NODE_COUNT(NODE_COUNT)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_type    (s_tuser),
		.in_node_a  (s_tdata[7:0]),
		.in_node_b  (s_tdata[15:8]),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_leader (leader),
		.out_status (status)
	);

	assign m_tdata = {6'd0, status, leader};

endmodule

`default_nettype wire

### dv/union_find_checker.sv
// Checker for the union-find core: tracks the sets and compares every result.
`default_nettype none

module union_find_checker
	import dsu_pkg::*;
#(
	parameter int NODES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [15:0] s_tdata,  // [7:0] node_a, [15:8] node_b
	input  wire logic [1:0]  s_tuser,  // [1:0] req_type
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,  // [7:0] leader, [9:8] status, [15:10] zero
	output int unsigned      mismatches,
	output int unsigned      outstanding
);

	localparam logic [8:0] LIST_END = 9'(NODES);

	typedef struct packed {
		logic [7:0] leader;
		logic [1:0] status;
	} lookup_t;

	logic       present     [NODES];
	logic [7:0] leader_of   [NODES];
	logic [8:0] next_member [NODES];
	logic [8:0] set_size    [NODES];

	lookup_t     results_due[$];
	lookup_t     want;
	int unsigned fail_count;

	assign mismatches = fail_count;

	// relabel the losing list, tail included, then hang it off the winner's tail
	function automatic void splice_sets(logic [7:0] winner, logic [7:0] loser);
		logic [8:0] walk;
		logic [7:0] tail;
		int         steps;
		walk  = {1'b0, loser};
		steps = 0;
		while (walk < LIST_END && steps < NODES) begin
			leader_of[walk[7:0]] = winner;
			walk = next_member[walk[7:0]];
			steps++;
		end
		tail  = winner;
		steps = 0;
		while (next_member[tail] < LIST_END && steps < NODES) begin
			tail = next_member[tail][7:0];
			steps++;
		end
		next_member[tail] = {1'b0, loser};
		set_size[winner]  = set_size[winner] + set_size[loser];
	endfunction

	function automatic lookup_t resolve_request(logic [1:0] kind, logic [7:0] a, logic [7:0] b);
		lookup_t    res;
		logic [7:0] la;
		logic [7:0] lb;
		res.leader = '0;
		res.status = ST_ABSENT;
		if (kind == REQ_ADD) begin
			if (present[a]) begin
				res.leader = leader_of[a];
				res.status = ST_DUP;
			end else begin
				present[a]     = 1'b1;
				leader_of[a]   = a;
				next_member[a] = LIST_END;
				set_size[a]    = 9'd1;
				res.leader     = a;
				res.status     = ST_OK;
			end
		end else if (!present[a]) begin
			res.status = ST_ABSENT;
		end else if (kind == REQ_MERGE) begin
			if (present[b]) begin
				la         = leader_of[a];
				lb         = leader_of[b];
				res.status = ST_OK;
				if (la == lb) begin
					res.leader = la;
				end else if (set_size[la] < set_size[lb]) begin
					splice_sets(lb, la);
					res.leader = lb;
				end else begin
					// ties go to node_a's set
					splice_sets(la, lb);
					res.leader = la;
				end
			end
		end else begin
			// find, and the spare code decodes as find
			res.leader = leader_of[a];
			res.status = ST_OK;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NODES; n++)
				present[n] = 1'b0;
			results_due.delete();
			fail_count  = 0;
			outstanding <= 0;
		end else begin
			// result side first: a result never belongs to a request taken on the same edge
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					fail_count++;
					$error("result with no request waiting: leader %0d status %0d",
						m_tdata[7:0], m_tdata[9:8]);
				end else begin
					want = results_due.pop_front();
					if (m_tdata[7:0] !== want.leader) begin
						fail_count++;
						$error("leader mismatch: expected %0d, got %0d", want.leader, m_tdata[7:0]);
					end
					if (m_tdata[9:8] !== want.status) begin
						fail_count++;
						$error("status mismatch: expected %0d, got %0d", want.status, m_tdata[9:8]);
					end
				end
			end
			if (s_tvalid && s_tready)
				results_due.push_back(resolve_request(s_tuser, s_tdata[7:0], s_tdata[15:8]));
			outstanding <= results_due.size();
		end
	end

endmodule

`default_nettype wire

### dv/tb_disjoint_set_union_find_core.sv
// Testbench top for the union-find core: stimulus, flow control and verdict.
`default_nettype none

module tb_disjoint_set_union_find_core;
	import dsu_pkg::*;

	localparam logic [1:0] REQ_SPARE    = 2'd3;  // unused code, decoded as find
	localparam int         IDLE_LIMIT   = 4000;
	localparam int         DRAIN_CYCLES = 300;
	localparam int         WINDOWS      = 8;
	localparam int         WINDOW_SPAN  = 32;
	localparam int         WINDOW_ITEMS = 185;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	int unsigned mismatches;
	int unsigned outstanding;
	logic        calm;        // no idling on either side while set
	int unsigned ready_hold;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	disjoint_set_union_find_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	union_find_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// mostly no pause, some short ones, a few long ones
	function automatic int unsigned pause_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 2) == 0) begin
			m_tready   <= 1'b0;
			ready_hold <= pause_len();
		end else begin
			m_tready   <= 1'b1;
			ready_hold <= $urandom_range(0, 6);
		end
	end

	task automatic issue(input logic [1:0] kind, input logic [7:0] a, input logic [7:0] b);
		int unsigned gap;
		gap = calm ? 0 : pause_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// hold the request side until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned base;
		int unsigned r;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [1:0]  kind;

		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= REQ_ADD;
		m_tready   <= 1'b0;
		ready_hold <= 0;
		calm       <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: absent nodes, duplicates, self merge, ties, both merge directions
		issue(REQ_FIND, 8'd0, 8'd0);
		issue(REQ_MERGE, 8'd0, 8'd255);
		issue(REQ_ADD, 8'd0, 8'd0);
		issue(REQ_ADD, 8'd255, 8'd255);
		issue(REQ_ADD, 8'd0, 8'd0);
		issue(REQ_MERGE, 8'd0, 8'd7);
		issue(REQ_MERGE, 8'd0, 8'd0);
		issue(REQ_FIND, 8'd255, 8'd0);
		issue(REQ_SPARE, 8'd255, 8'd0);
		issue(REQ_MERGE, 8'd0, 8'd255);
		issue(REQ_ADD, 8'd128, 8'd0);
		issue(REQ_ADD, 8'd127, 8'd0);
		issue(REQ_MERGE, 8'd128, 8'd0);
		issue(REQ_FIND, 8'd128, 8'd0);
		issue(REQ_MERGE, 8'd255, 8'd128);
		issue(REQ_MERGE, 8'd127, 8'd255);
		issue(REQ_ADD, 8'd255, 8'd0);
		issue(REQ_SPARE, 8'd5, 8'd255);
		issue(REQ_MERGE, 8'd5, 8'd0);
		issue(REQ_ADD, 8'd170, 8'd0);
		issue(REQ_ADD, 8'd85, 8'd0);
		issue(REQ_MERGE, 8'd85, 8'd170);
		issue(REQ_FIND, 8'd170, 8'd255);
		drain();

		// random: a sliding window of nodes builds small sets, cross merges grow long lists
		for (int w = 0; w < WINDOWS; w++) begin
			base = w * WINDOW_SPAN;
			for (int i = 0; i < WINDOW_ITEMS; i++) begin
				if (i % 60 == 0)
					calm <= ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				a = 8'(base + $urandom_range(0, WINDOW_SPAN - 1));
				b = 8'(base + $urandom_range(0, WINDOW_SPAN - 1));
				if (r < 25) begin
					kind = REQ_ADD;
				end else if (r < 45) begin
					kind = REQ_FIND;
				end else if (r < 80) begin
					kind = REQ_MERGE;
					if ($urandom_range(0, 9) < 3)
						b = 8'($urandom_range(0, base + WINDOW_SPAN - 1));
				end else if (r < 88) begin
					kind = REQ_SPARE;
					a    = 8'($urandom_range(0, 255));
				end else begin
					kind = 2'($urandom_range(0, 3));
					a    = 8'($urandom_range(0, 255));
					b    = 8'($urandom_range(0, 255));
				end
				issue(kind, a, b);
			end
			drain();
		end

		calm <= 1'b1;
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
